/* rtl/core/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants of the complex sliding correlator
// Window geometry, field widths, register indexes, controller/datapath
// command and status bundles, saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

   // Delay line and reference table depth
   localparam int WINDOW      = 128;
   localparam int ADDR_W      = $clog2(WINDOW);
   localparam int ADDR_P1_W   = ADDR_W + 1;
   localparam int LEN_W       = $clog2(WINDOW + 1);
   localparam int DIV_CNT_W   = $clog2(LEN_W);

   // Field widths
   localparam int SAMP_W      = 16;
   localparam int PROD_W      = 2 * SAMP_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int ACC_W       = SUM_W + ADDR_W;
   localparam int CORR_W      = 40;
   localparam int TOTAL_W     = 48;
   localparam int TOTAL_SUM_W = TOTAL_W + 1;
   localparam int REF_IDX_W   = 7;
   localparam int DEC_W       = 4;
   localparam int RLEN_W      = 8;
   localparam int PHASE_W     = 3;
   localparam int DEC_MAX     = 8;
   localparam int REM_W       = 4;

   // Configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_IDX_W-1:0] REG_DECIMATE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_LENGTH = 1'd1;
   localparam logic [DEC_W-1:0]     DECIMATE_RESET   = 4'd1;
   localparam logic [RLEN_W-1:0]    REF_LENGTH_RESET = 8'd128;

   // Input item codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic signed [63:0] CORR_MAX  = 64'sd549755813887;
   localparam logic signed [63:0] CORR_MIN  = -64'sd549755813888;
   localparam logic signed [63:0] TOTAL_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] TOTAL_MIN = -64'sd140737488355328;

   typedef struct packed {
      logic ready;
      logic div_step;
      logic line_write;
      logic run_issue;
      logic emit;
   } csc_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_load;
      logic req_last;
      logic phase_zero;
      logic div_done;
      logic taps_zero;
      logic run_last;
      logic pipe_busy;
      logic rsp_free;
   } csc_sts_type;

   // Reference slot of a load index, taken modulo the window
   function automatic logic [ADDR_W-1:0] ref_slot(input logic [REF_IDX_W-1:0] idx);
      logic [REF_IDX_W:0] v;
      v = {1'b0, idx};
      for (int i = 0; i < (1 << REF_IDX_W) / WINDOW; i++) begin
         if (v >= (REF_IDX_W + 1)'(WINDOW)) begin
            v = v - (REF_IDX_W + 1)'(WINDOW);
         end
      end
      return ADDR_W'(v);
   endfunction

   function automatic logic signed [CORR_W-1:0] sat_corr(input logic signed [ACC_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > CORR_MAX) begin
         w = CORR_MAX;
      end else if (w < CORR_MIN) begin
         w = CORR_MIN;
      end
      return CORR_W'(w);
   endfunction

   function automatic logic signed [TOTAL_W-1:0] sat_total(
      input logic signed [TOTAL_SUM_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > TOTAL_MAX) begin
         w = TOTAL_MAX;
      end else if (w < TOTAL_MIN) begin
         w = TOTAL_MIN;
      end
      return TOTAL_W'(w);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/csc_req_if.sv */
// ----------------------------------------------------------------------------
// csc_req_if: input item channel
// Valid/ready channel carrying sample and reference-load items.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   op;
   logic                                   last_of_vector;
   logic signed [csc_pkg::SAMP_W-1:0]      sample_re;
   logic signed [csc_pkg::SAMP_W-1:0]      sample_im;
   logic        [csc_pkg::REF_IDX_W-1:0]   ref_index;
   logic signed [csc_pkg::SAMP_W-1:0]      ref_re;
   logic signed [csc_pkg::SAMP_W-1:0]      ref_im;

   modport source (
      output valid, op, last_of_vector, sample_re, sample_im, ref_index, ref_re, ref_im,
      input  ready
   );

   modport sink (
      input  valid, op, last_of_vector, sample_re, sample_im, ref_index, ref_re, ref_im,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/csc_rsp_if.sv */
// ----------------------------------------------------------------------------
// csc_rsp_if: result channel
// Valid/ready channel carrying correlation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [csc_pkg::CORR_W-1:0]      corr_re;
   logic signed [csc_pkg::CORR_W-1:0]      corr_im;
   logic signed [csc_pkg::TOTAL_W-1:0]     total_re;
   logic                                   is_final;

   modport source (
      output valid, corr_re, corr_im, total_re, is_final,
      input  ready
   );

   modport sink (
      input  valid, corr_re, corr_im, total_re, is_final,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/complex_sliding_correlator.sv */
// ----------------------------------------------------------------------------
// complex_sliding_correlator: decimating complex sliding correlator
// Reference table load, decimated circular delay line, conjugate correlation
// against strided reference taps, saturating running total per vector.
// ----------------------------------------------------------------------------
// Load items write one Q1.15 complex reference entry. Sample items skipped
// by the decimator give no result unless they close a vector, when they
// produce the final result. A kept sample passes through intake, a
// bit-serial ref_length/decimate divide, one delay-line write, a walk of
// the taps through the single shared complex multiply-accumulate (one read
// of each RAM per tap), pipeline drain and the load of the result register.
// The result register lets the next item enter while a result waits; the
// block stalls only if a second result is ready before the first transfers.
// Delay-line clearing at the end of a vector is immediate (per-entry valid
// bits), so no clearing pass is needed. The user must write configuration
// only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_sliding_correlator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   csc_req_if.sink                             req_chan,
   csc_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [csc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [csc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   csc_pkg::csc_cmd_type cmd;
   csc_pkg::csc_sts_type sts;

   csc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   csc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

/* rtl/core/csc_ram.sv */
// ----------------------------------------------------------------------------
// csc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/csc_ctrl.sv */
// ----------------------------------------------------------------------------
// csc_ctrl: correlator sequencer
// Steps each kept sample through tap-count divide, delay-line write, tap walk,
// pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csc_pkg::csc_sts_type  sts,
   output csc_pkg::csc_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_WRITE,
      S_RUN,
      S_DRAIN,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (sts.req_valid && !sts.req_load) begin
               if (sts.phase_zero) begin
                  state_in = S_DIV;
               end else if (sts.req_last) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // no taps: skip the line, give a zero correlation
            if (sts.taps_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.line_write = 1'b1;
               state_in       = S_RUN;
            end
         end
         S_RUN: begin
            cmd.run_issue = 1'b1;
            if (sts.run_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/csc_dp.sv */
// ----------------------------------------------------------------------------
// csc_dp: correlator datapath
// Config registers, decimator, tap-count divider, delay line and reference
// RAMs, shared complex multiply-accumulate, running total, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   csc_req_if.sink                                req_chan,
   csc_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [csc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [csc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire csc_pkg::csc_cmd_type              cmd,
   output csc_pkg::csc_sts_type                   sts
);

   // ---------------- configuration ----------------
   logic [csc_pkg::DEC_W-1:0]  decimate_ff;
   logic [csc_pkg::RLEN_W-1:0] ref_length_ff;
   logic [csc_pkg::DEC_W-1:0]  dec_eff;
   logic [csc_pkg::LEN_W-1:0]  len_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimate_ff   <= csc_pkg::DECIMATE_RESET;
         ref_length_ff <= csc_pkg::REF_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            csc_pkg::REG_DECIMATE:   decimate_ff   <= csr_wdata[csc_pkg::DEC_W-1:0];
            csc_pkg::REG_REF_LENGTH: ref_length_ff <= csr_wdata[csc_pkg::RLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (decimate_ff == '0) begin
         dec_eff = csc_pkg::DEC_W'(1);
      end else if (decimate_ff > csc_pkg::DEC_W'(csc_pkg::DEC_MAX)) begin
         dec_eff = csc_pkg::DEC_W'(csc_pkg::DEC_MAX);
      end else begin
         dec_eff = decimate_ff;
      end
      if (32'(ref_length_ff) > csc_pkg::WINDOW) begin
         len_eff = csc_pkg::LEN_W'(csc_pkg::WINDOW);
      end else begin
         len_eff = csc_pkg::LEN_W'(ref_length_ff);
      end
   end

   // ---------------- item intake ----------------
   logic accept;
   logic take_sample;
   logic take_load;

   assign req_chan.ready = cmd.ready;
   assign accept         = cmd.ready & req_chan.valid;
   assign take_sample    = accept & (req_chan.op == csc_pkg::OP_SAMPLE);
   assign take_load      = accept & (req_chan.op == csc_pkg::OP_LOAD);

   logic signed [csc_pkg::SAMP_W-1:0] samp_re_ff;
   logic signed [csc_pkg::SAMP_W-1:0] samp_im_ff;
   logic                              last_ff;
   logic [csc_pkg::PHASE_W-1:0]       phase_ff;
   logic [csc_pkg::PHASE_W-1:0]       phase_in;
   logic [csc_pkg::PHASE_W:0]         phase_inc;

   assign phase_inc = {1'b0, phase_ff} + 1'b1;
   assign phase_in  = (phase_inc >= dec_eff) ? '0 : phase_inc[csc_pkg::PHASE_W-1:0];

   always_ff @(posedge clock) begin
      if (take_sample) begin
         samp_re_ff <= req_chan.sample_re;
         samp_im_ff <= req_chan.sample_im;
         last_ff    <= req_chan.last_of_vector;
      end
   end

   // ---------------- tap count divider (one quotient bit a cycle) ----------------
   logic [csc_pkg::LEN_W-1:0]     div_num_ff;
   logic [csc_pkg::REM_W-1:0]     div_rem_ff;
   logic [csc_pkg::REM_W-1:0]     div_rem_in;
   logic [csc_pkg::REM_W-1:0]     rem_sh;
   logic                          rem_ge;
   logic [csc_pkg::LEN_W-1:0]     taps_ff;
   logic [csc_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   assign rem_sh     = {div_rem_ff[csc_pkg::REM_W-2:0], div_num_ff[csc_pkg::LEN_W-1]};
   assign rem_ge     = rem_sh >= dec_eff;
   assign div_rem_in = rem_ge ? rem_sh - dec_eff : rem_sh;

   always_ff @(posedge clock) begin
      if (take_sample) begin
         div_num_ff <= len_eff;
         div_rem_ff <= '0;
         taps_ff    <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[csc_pkg::LEN_W-2:0], 1'b0};
         div_rem_ff <= div_rem_in;
         taps_ff    <= {taps_ff[csc_pkg::LEN_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // ---------------- delay line addressing ----------------
   logic [csc_pkg::ADDR_W-1:0]    wp_ff;
   logic [csc_pkg::ADDR_W-1:0]    wp_eff;
   logic [csc_pkg::ADDR_W-1:0]    wp_in;
   logic [csc_pkg::ADDR_W-1:0]    pos_ff;
   logic [csc_pkg::ADDR_W-1:0]    pos_in;
   logic [csc_pkg::LEN_W-1:0]     pos_inc;
   logic [csc_pkg::ADDR_W-1:0]    raddr_ff;
   logic [csc_pkg::ADDR_W-1:0]    raddr_in;
   logic [csc_pkg::ADDR_P1_W-1:0] raddr_sum;
   logic [csc_pkg::LEN_W-1:0]     k_ff;
   logic [csc_pkg::WINDOW-1:0]    line_vld_ff;

   assign wp_eff    = (csc_pkg::LEN_W'(wp_ff) >= taps_ff) ? '0 : wp_ff;
   assign wp_in     = (wp_eff == '0) ? csc_pkg::ADDR_W'(taps_ff - 1'b1) : wp_eff - 1'b1;
   assign pos_inc   = csc_pkg::LEN_W'(pos_ff) + 1'b1;
   assign pos_in    = (pos_inc >= taps_ff) ? '0 : csc_pkg::ADDR_W'(pos_inc);
   assign raddr_sum = {1'b0, raddr_ff} + csc_pkg::ADDR_P1_W'(dec_eff);
   assign raddr_in  = (raddr_sum >= csc_pkg::ADDR_P1_W'(csc_pkg::WINDOW))
                    ? csc_pkg::ADDR_W'(raddr_sum - csc_pkg::ADDR_P1_W'(csc_pkg::WINDOW))
                    : csc_pkg::ADDR_W'(raddr_sum);

   always_ff @(posedge clock) begin
      if (cmd.line_write) begin
         pos_ff   <= wp_eff;
         raddr_ff <= '0;
         k_ff     <= '0;
      end else if (cmd.run_issue) begin
         pos_ff   <= pos_in;
         raddr_ff <= raddr_in;
         k_ff     <= k_ff + 1'b1;
      end
   end

   // ---------------- memories ----------------
   logic [csc_pkg::PROD_W-1:0] ref_rdata;
   logic [csc_pkg::PROD_W-1:0] line_rdata;

   csc_ram #(
      .WIDTH (csc_pkg::PROD_W),
      .DEPTH (csc_pkg::WINDOW)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (take_load),
      .wr_addr (csc_pkg::ref_slot(req_chan.ref_index)),
      .wr_data ({req_chan.ref_re, req_chan.ref_im}),
      .rd_en   (cmd.run_issue),
      .rd_addr (raddr_ff),
      .rd_data (ref_rdata)
   );

   csc_ram #(
      .WIDTH (csc_pkg::PROD_W),
      .DEPTH (csc_pkg::WINDOW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.line_write),
      .wr_addr (wp_eff),
      .wr_data ({samp_re_ff, samp_im_ff}),
      .rd_en   (cmd.run_issue),
      .rd_addr (pos_ff),
      .rd_data (line_rdata)
   );

   // ---------------- complex multiply-accumulate ----------------
   logic                              rd_vld_ff;
   logic                              tap_vld_ff;
   logic                              prod_vld_ff;
   logic signed [csc_pkg::SAMP_W-1:0] x_re;
   logic signed [csc_pkg::SAMP_W-1:0] x_im;
   logic signed [csc_pkg::SAMP_W-1:0] r_re;
   logic signed [csc_pkg::SAMP_W-1:0] r_im;
   logic signed [csc_pkg::PROD_W-1:0] prod_rr_ff;
   logic signed [csc_pkg::PROD_W-1:0] prod_ii_ff;
   logic signed [csc_pkg::PROD_W-1:0] prod_ir_ff;
   logic signed [csc_pkg::PROD_W-1:0] prod_ri_ff;
   logic signed [csc_pkg::SUM_W-1:0]  sum_re;
   logic signed [csc_pkg::SUM_W-1:0]  sum_im;
   logic signed [csc_pkg::ACC_W-1:0]  acc_re_ff;
   logic signed [csc_pkg::ACC_W-1:0]  acc_im_ff;

   // entries not written since the vector started read as zero
   assign x_re = tap_vld_ff ? $signed(line_rdata[csc_pkg::PROD_W-1:csc_pkg::SAMP_W]) : '0;
   assign x_im = tap_vld_ff ? $signed(line_rdata[csc_pkg::SAMP_W-1:0]) : '0;
   assign r_re = $signed(ref_rdata[csc_pkg::PROD_W-1:csc_pkg::SAMP_W]);
   assign r_im = $signed(ref_rdata[csc_pkg::SAMP_W-1:0]);

   assign sum_re = csc_pkg::SUM_W'(prod_rr_ff) + csc_pkg::SUM_W'(prod_ii_ff);
   assign sum_im = csc_pkg::SUM_W'(prod_ir_ff) - csc_pkg::SUM_W'(prod_ri_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.run_issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run_issue) begin
         tap_vld_ff <= line_vld_ff[pos_ff];
      end
      if (rd_vld_ff) begin
         prod_rr_ff <= x_re * r_re;
         prod_ii_ff <= x_im * r_im;
         prod_ir_ff <= x_im * r_re;
         prod_ri_ff <= x_re * r_im;
      end
      if (take_sample) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_re_ff <= acc_re_ff + csc_pkg::ACC_W'(sum_re);
         acc_im_ff <= acc_im_ff + csc_pkg::ACC_W'(sum_im);
      end
   end

   // ---------------- running total and result register ----------------
   logic signed [csc_pkg::CORR_W-1:0]      corr_re_sat;
   logic signed [csc_pkg::CORR_W-1:0]      corr_im_sat;
   logic signed [csc_pkg::TOTAL_SUM_W-1:0] total_sum;
   logic signed [csc_pkg::TOTAL_W-1:0]     total_new;
   logic signed [csc_pkg::TOTAL_W-1:0]     total_ff;
   logic                                   rsp_valid_ff;
   logic signed [csc_pkg::CORR_W-1:0]      rsp_corr_re_ff;
   logic signed [csc_pkg::CORR_W-1:0]      rsp_corr_im_ff;
   logic signed [csc_pkg::TOTAL_W-1:0]     rsp_total_ff;
   logic                                   rsp_final_ff;
   logic                                   rsp_free;

   // skipped samples leave the accumulator at zero, so the total holds
   assign corr_re_sat = csc_pkg::sat_corr(acc_re_ff);
   assign corr_im_sat = csc_pkg::sat_corr(acc_im_ff);
   assign total_sum   = csc_pkg::TOTAL_SUM_W'(total_ff) + csc_pkg::TOTAL_SUM_W'(corr_re_sat);
   assign total_new   = csc_pkg::sat_total(total_sum);
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         phase_ff     <= '0;
         wp_ff        <= '0;
         line_vld_ff  <= '0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take_sample) begin
            phase_ff <= phase_in;
         end
         if (cmd.line_write) begin
            wp_ff               <= wp_in;
            line_vld_ff[wp_eff] <= 1'b1;
         end
         if (cmd.emit) begin
            // end of vector: clear line, position, phase and total
            if (last_ff) begin
               total_ff    <= '0;
               phase_ff    <= '0;
               wp_ff       <= '0;
               line_vld_ff <= '0;
            end else begin
               total_ff <= total_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_corr_re_ff <= corr_re_sat;
         rsp_corr_im_ff <= corr_im_sat;
         rsp_total_ff   <= total_new;
         rsp_final_ff   <= last_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.corr_re  = rsp_corr_re_ff;
   assign rsp_chan.corr_im  = rsp_corr_im_ff;
   assign rsp_chan.total_re = rsp_total_ff;
   assign rsp_chan.is_final = rsp_final_ff;

   // ---------------- status ----------------
   always_comb begin
      sts            = '0;
      sts.req_valid  = req_chan.valid;
      sts.req_load   = req_chan.op == csc_pkg::OP_LOAD;
      sts.req_last   = req_chan.last_of_vector;
      sts.phase_zero = phase_ff == '0;
      sts.div_done   = div_cnt_ff == csc_pkg::DIV_CNT_W'(csc_pkg::LEN_W - 1);
      sts.taps_zero  = taps_ff == '0;
      sts.run_last   = k_ff == taps_ff - 1'b1;
      sts.pipe_busy  = rd_vld_ff | prod_vld_ff;
      sts.rsp_free   = rsp_free;
   end

`ifndef ASSERT_OFF
   a_write_needs_taps: assert property (@(posedge clock) disable iff (reset)
      cmd.line_write |-> taps_ff != '0)
      else $error("delay line written with zero taps");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.run_issue |-> k_ff < taps_ff)
      else $error("tap walk ran past tap count");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && last_ff) |=> (total_ff == '0 && line_vld_ff == '0 && phase_ff == '0))
      else $error("vector state not cleared after final result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire
